>>> src/eic_pkg.sv
// ----------------------------------------------------------------------------
// eic_pkg
// Shared types and constants of the ELF64 image checker.
// ----------------------------------------------------------------------------
`default_nettype none

package eic_pkg;

  localparam int unsigned HDR_BYTES = 64;
  localparam int unsigned ENT_BYTES = 56;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_ENTRY    = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [1:0] CFG_LEN   = 2'd0;
  localparam logic [1:0] CFG_ENTRY = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;
  localparam logic [1:0] CFG_PAGE  = 2'd3;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_SHORT,
    JOB_HDR,
    JOB_ENT
  } job_kind_t;

  // Header job: a = phoff, b = phnum, pre_ok = format fields ok, flag = no entries.
  // Entry job:  a = offset, b = paddr, c = filesz, d = memsz,
  //             pre_ok = PT_LOAD, flag = final entry.
  typedef struct packed {
    job_kind_t   kind;
    logic        last;
    logic        flag;
    logic        pre_ok;
    logic [63:0] entry;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } job_t;

endpackage

`default_nettype wire

>>> src/eic_front.sv
// ----------------------------------------------------------------------------
// eic_front
// Byte capture: header and entry shift lines, position tracking, job build.
// ----------------------------------------------------------------------------
`default_nettype none

module eic_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          beat,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  input  wire logic [63:0]   image_length,
  output eic_pkg::job_t      job,
  output logic               job_push
);
  import eic_pkg::*;

  logic [63:0]  pos_r, pos_nxt;
  logic [511:0] hdr_r, hdr_nxt, hdr_full;
  logic [447:0] ent_r, ent_nxt, ent_full;
  logic [5:0]   k_r, k_nxt;
  logic [15:0]  es_r, es_nxt;
  logic         in_table, is_short, is_hdr, is_ent, fmt_ok;
  logic [63:0]  phoff;
  logic [15:0]  phnum, f_phnum;

  assign hdr_full = {data_byte, hdr_r[511:8]};
  assign ent_full = {data_byte, ent_r[447:8]};
  assign phoff    = hdr_r[32*8 +: 64];
  assign phnum    = hdr_r[56*8 +: 16];
  assign f_phnum  = hdr_full[56*8 +: 16];

  assign is_short = (pos_r == 64'd0) && (image_length < 64'(HDR_BYTES));
  assign is_hdr   = !is_short && (pos_r == 64'(HDR_BYTES - 1));
  assign in_table = (pos_r >= 64'(HDR_BYTES)) && (pos_r >= phoff);
  assign is_ent   = in_table && (k_r == 6'(ENT_BYTES - 1));

  assign fmt_ok = (hdr_full[7:0] == 8'h7f) && (hdr_full[15:8] == 8'h45) &&
                  (hdr_full[23:16] == 8'h4c) && (hdr_full[31:24] == 8'h46) &&
                  (hdr_full[39:32] == 8'd2) && (hdr_full[47:40] == 8'd1) &&
                  (hdr_full[55:48] == 8'd1) &&
                  (hdr_full[16*8 +: 16] == 16'd2) &&
                  (hdr_full[18*8 +: 16] == 16'd183) &&
                  (hdr_full[20*8 +: 32] == 32'd1) &&
                  (hdr_full[52*8 +: 16] == 16'(HDR_BYTES)) &&
                  (hdr_full[54*8 +: 16] == 16'(ENT_BYTES));

  always_comb begin
    job        = '0;
    job.last   = last_byte;
    job.entry  = (pos_r == 64'(HDR_BYTES - 1)) ? hdr_full[24*8 +: 64] : hdr_r[24*8 +: 64];
    job.kind   = JOB_NONE;
    if (is_short) begin
      job.kind = JOB_SHORT;
    end else if (is_hdr) begin
      job.kind   = JOB_HDR;
      job.pre_ok = fmt_ok;
      job.flag   = (f_phnum == 16'd0);
      job.a      = hdr_full[32*8 +: 64];
      job.b      = 64'(f_phnum);
    end else if (is_ent) begin
      job.kind   = JOB_ENT;
      job.pre_ok = (ent_full[31:0] == 32'd1);
      job.flag   = ({1'b0, es_r} + 17'd1) >= {1'b0, phnum};
      job.a      = ent_full[8*8 +: 64];
      job.b      = ent_full[24*8 +: 64];
      job.c      = ent_full[32*8 +: 64];
      job.d      = ent_full[40*8 +: 64];
    end
    job_push = beat && ((job.kind != JOB_NONE) || last_byte);
  end

  always_comb begin
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    ent_nxt = ent_r;
    k_nxt   = k_r;
    es_nxt  = es_r;
    if (beat) begin
      if (pos_r < 64'(HDR_BYTES)) hdr_nxt = hdr_full;
      if (in_table) begin
        ent_nxt = ent_full;
        if (k_r == 6'(ENT_BYTES - 1)) begin
          k_nxt  = '0;
          es_nxt = es_r + 16'd1;
        end else begin
          k_nxt = k_r + 6'd1;
        end
      end
      if (last_byte) begin
        pos_nxt = '0;
        k_nxt   = '0;
        es_nxt  = '0;
      end else if (pos_r != {64{1'b1}}) begin
        pos_nxt = pos_r + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    ent_r <= ent_nxt;
    if (!rst_n) begin
      pos_r <= '0;
      k_r   <= '0;
      es_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      k_r   <= k_nxt;
      es_r  <= es_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/eic_queue.sv
// ----------------------------------------------------------------------------
// eic_queue
// Small job FIFO between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module eic_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire eic_pkg::job_t wr_job,
  input  wire logic          pop,
  output eic_pkg::job_t      rd_job,
  output logic               empty,
  output logic               has_room
);
  import eic_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t                 mem [DEPTH];
  logic [AW-1:0]        wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  assign empty    = (cnt_r == '0);
  assign has_room = (cnt_r != ($clog2(DEPTH+1))'(DEPTH));
  assign rd_job   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + ($clog2(DEPTH+1))'(push) - ($clog2(DEPTH+1))'(pop);
    end
  end

endmodule

`default_nettype wire

>>> src/eic_back.sv
// ----------------------------------------------------------------------------
// eic_back
// Three-stage judge pipeline: sums, overflow and bound compares, verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module eic_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire eic_pkg::job_t job,
  input  wire logic          job_valid,
  output logic               job_pop,
  input  wire logic [63:0]   image_length,
  input  wire logic [63:0]   required_entry,
  input  wire logic [63:0]   handoff_limit,
  input  wire logic [4:0]    page_shift,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         out_status,
  output logic [63:0]        out_entry
);
  import eic_pkg::*;

  typedef struct packed {
    logic        vld;
    job_kind_t   kind;
    logic        last;
    logic        flag;
    logic        pre_ok;
    logic        b1;
    logic        low;
    logic [63:0] entry;
    logic [64:0] sum1;
    logic [64:0] sum2;
  } s1_t;

  typedef struct packed {
    logic        vld;
    job_kind_t   kind;
    logic        last;
    logic        flag;
    logic        pre_ok;
    logic        b1;
    logic        low;
    logic        ovf1;
    logic        gt1;
    logic        ovf2;
    logic [63:0] entry;
    logic [64:0] sum3;
  } s2_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  logic        adv, dec_r, dec_nxt, emit, ov_nxt;
  logic [2:0]  st;
  logic [21:0] tb;
  logic [63:0] mask;
  logic        ovf3, rgt;
  logic        val_r;
  logic [2:0]  st_r;
  logic [63:0] ent_r;

  assign adv     = !val_r || out_ready;
  assign job_pop = adv && job_valid;
  assign mask    = (64'd1 << page_shift) - 64'd1;

  // phnum * 56 as three shifted terms
  assign tb = {1'b0, job.b[15:0], 5'b0} + {2'b0, job.b[15:0], 4'b0} +
              {3'b0, job.b[15:0], 3'b0};

  always_comb begin
    s1_nxt        = '0;
    s1_nxt.vld    = job_valid;
    s1_nxt.kind   = job.kind;
    s1_nxt.last   = job.last;
    s1_nxt.flag   = job.flag;
    s1_nxt.pre_ok = job.pre_ok;
    s1_nxt.entry  = job.entry;
    s1_nxt.low    = job.a < 64'(HDR_BYTES);
    if (job.kind == JOB_HDR) begin
      s1_nxt.b1   = (job.entry == required_entry);
      s1_nxt.sum1 = {1'b0, job.a} + 65'(tb);
    end else begin
      s1_nxt.b1   = job.c > job.d;
      s1_nxt.sum1 = {1'b0, job.a} + {1'b0, job.c};
      s1_nxt.sum2 = {1'b0, job.b} + {1'b0, job.d};
    end
  end

  always_comb begin
    s2_nxt        = '0;
    s2_nxt.vld    = s1_r.vld;
    s2_nxt.kind   = s1_r.kind;
    s2_nxt.last   = s1_r.last;
    s2_nxt.flag   = s1_r.flag;
    s2_nxt.pre_ok = s1_r.pre_ok;
    s2_nxt.b1     = s1_r.b1;
    s2_nxt.low    = s1_r.low;
    s2_nxt.entry  = s1_r.entry;
    s2_nxt.ovf1   = s1_r.sum1[64];
    s2_nxt.gt1    = s1_r.sum1[63:0] > image_length;
    s2_nxt.ovf2   = s1_r.sum2[64];
    s2_nxt.sum3   = {1'b0, s1_r.sum2[63:0]} + {1'b0, mask};
  end

  assign ovf3 = s2_r.sum3[64];
  assign rgt  = (s2_r.sum3[63:0] & ~mask) > handoff_limit;

  always_comb begin
    st   = ST_OK;
    emit = 1'b0;
    case (s2_r.kind)
      JOB_SHORT: begin
        st   = ST_HEADER;
        emit = 1'b1;
      end
      JOB_HDR: begin
        if (!s2_r.pre_ok)                st = ST_HEADER;
        else if (!s2_r.b1)               st = ST_ENTRY;
        else if (s2_r.ovf1)              st = ST_OVERFLOW;
        else if (s2_r.gt1 || s2_r.low)   st = ST_HEADER;
        emit = (st != ST_OK) || s2_r.flag;
      end
      JOB_ENT: begin
        if (!s2_r.pre_ok)   st = ST_OK;
        else if (s2_r.b1)   st = ST_RANGE;
        else if (s2_r.ovf1) st = ST_OVERFLOW;
        else if (s2_r.gt1)  st = ST_RANGE;
        else if (s2_r.ovf2) st = ST_OVERFLOW;
        else if (ovf3)      st = ST_OVERFLOW;
        else if (rgt)       st = ST_RANGE;
        emit = (st != ST_OK) || s2_r.flag;
      end
      default: begin
        st   = ST_OK;
        emit = 1'b0;
      end
    endcase
    if (!emit && s2_r.last) begin
      emit = 1'b1;
      st   = ST_HEADER;
    end
    ov_nxt  = s2_r.vld && emit && !dec_r;
    dec_nxt = dec_r;
    if (s2_r.vld) dec_nxt = s2_r.last ? 1'b0 : (dec_r || emit);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.kind   <= s1_nxt.kind;
      s1_r.last   <= s1_nxt.last;
      s1_r.flag   <= s1_nxt.flag;
      s1_r.pre_ok <= s1_nxt.pre_ok;
      s1_r.b1     <= s1_nxt.b1;
      s1_r.low    <= s1_nxt.low;
      s1_r.entry  <= s1_nxt.entry;
      s1_r.sum1   <= s1_nxt.sum1;
      s1_r.sum2   <= s1_nxt.sum2;
      s2_r.kind   <= s2_nxt.kind;
      s2_r.last   <= s2_nxt.last;
      s2_r.flag   <= s2_nxt.flag;
      s2_r.pre_ok <= s2_nxt.pre_ok;
      s2_r.b1     <= s2_nxt.b1;
      s2_r.low    <= s2_nxt.low;
      s2_r.ovf1   <= s2_nxt.ovf1;
      s2_r.gt1    <= s2_nxt.gt1;
      s2_r.ovf2   <= s2_nxt.ovf2;
      s2_r.entry  <= s2_nxt.entry;
      s2_r.sum3   <= s2_nxt.sum3;
      st_r        <= st;
      ent_r       <= (st == ST_OK) ? s2_r.entry : 64'd0;
    end
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      val_r    <= 1'b0;
      dec_r    <= 1'b0;
    end else if (adv) begin
      s1_r.vld <= s1_nxt.vld;
      s2_r.vld <= s2_nxt.vld;
      val_r    <= ov_nxt;
      dec_r    <= dec_nxt;
    end
  end

  assign out_valid  = val_r;
  assign out_status = st_r;
  assign out_entry  = ent_r;

endmodule

`default_nettype wire

>>> src/elf64_image_checker.sv
// ----------------------------------------------------------------------------
// elf64_image_checker
// Streams an ELF64 image byte by byte and emits one verdict per image.
// ----------------------------------------------------------------------------
// The image enters one byte per beat from offset 0; in_tlast marks its final
// byte. The block takes one byte every cycle while the job queue has room:
// the front captures the header and each program header entry in shift lines
// and queues a job at the end of each, and a three-stage judge pipeline works
// them off from the registered queue. A stalled result backs up the job
// queue; once it holds QUEUE_DEPTH jobs, in_tready drops for every byte until
// a job drains. Configuration must be written only while no image is in
// flight; the block itself does not enforce this.
`default_nettype none

module elf64_image_checker #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [2:0] status, [66:3] entry_point
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [63:0] cfg_wdata
);
  import eic_pkg::*;

  logic [63:0] len_r, req_r, lim_r;
  logic [4:0]  ps_r;
  job_t        f_job, q_job;
  logic        f_push, q_empty, q_room, q_pop, beat;
  logic [2:0]  st;
  logic [63:0] ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      req_r <= '0;
      lim_r <= '0;
      ps_r  <= 5'd12;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LEN:   len_r <= cfg_wdata;
        CFG_ENTRY: req_r <= cfg_wdata;
        CFG_LIMIT: lim_r <= cfg_wdata;
        CFG_PAGE:  ps_r  <= cfg_wdata[4:0];
        default:   ;
      endcase
    end
  end

  assign in_tready = q_room;
  assign beat      = in_tvalid && q_room;

  eic_front u_front (
    .clk, .rst_n, .beat,
    .data_byte(in_tdata), .last_byte(in_tlast),
    .image_length(len_r),
    .job(f_job), .job_push(f_push)
  );

  eic_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .push(f_push), .wr_job(f_job),
    .pop(q_pop), .rd_job(q_job),
    .empty(q_empty), .has_room(q_room)
  );

  eic_back u_back (
    .clk, .rst_n,
    .job(q_job), .job_valid(!q_empty), .job_pop(q_pop),
    .image_length(len_r), .required_entry(req_r),
    .handoff_limit(lim_r), .page_shift(ps_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(st), .out_entry(ent)
  );

  assign out_tdata = {5'd0, ent, st};

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == ST_OK || st == ST_HEADER || st == ST_ENTRY ||
                    st == ST_RANGE || st == ST_OVERFLOW))
    else $error("status code out of range");

  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && st != ST_OK) |-> (ent == 64'd0))
    else $error("entry point not cleared on failure");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result after reset");

endmodule

`default_nettype wire

>>> sim/elf64_image_checker_tb.sv
// ----------------------------------------------------------------------------
// elf64_image_checker_tb
// Self-checking bench for the ELF64 image checker.
// ----------------------------------------------------------------------------
// Builds ELF64 images, both well formed and with one chosen flaw, and streams
// them byte by byte with random gaps. A model of the checker in this file
// predicts each verdict. The bench compares every result beat with the oldest
// prediction. It also covers random noise images, register sweeps and a long
// stall on the result side.
`default_nettype none

module elf64_image_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eic_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum int {
    F_NONE, F_MAGIC, F_ENTRY, F_PHLOW, F_PHOVF, F_FILESZ, F_FILEEND,
    F_FILEOVF, F_LIMIT, F_SEGOVF, F_ROUNDOVF, F_NOLOAD, F_TRUNC
  } flaw_t;

  typedef struct {
    logic [2:0]  st;
    logic [63:0] entry;
  } verdict_t;

  typedef struct {
    logic [63:0] len;     // 0: size of the image
    logic [63:0] entry;
    logic [63:0] limit;
    logic [4:0]  shift;
    flaw_t       flaw;
    int          nph;
    int          gap;
    int          typed_st; // -1: from the model below
  } case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_LEN;
  logic [63:0] cfg_wdata = '0;

  elf64_image_checker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // checker model state
  logic [63:0] m_len, m_entry, m_limit;
  logic [4:0]  m_shift;
  logic [63:0] m_pos;
  logic [7:0]  m_hdr [64];
  logic [7:0]  m_ent [64];
  logic [15:0] m_seen;
  logic        m_done;

  verdict_t    verdict_q[$];
  int          forced_st = -1;
  int          errors = 0;
  int          n_results = 0;
  int          n_bytes = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          long_stall = 1'b0;
  logic [7:0]  img[];

  function automatic logic [63:0] le(input logic [7:0] a [64], input int at, input int n);
    logic [63:0] v;
    v = '0;
    for (int i = n - 1; i >= 0; i--) v = (v << 8) | a[at + i];
    return v;
  endfunction

  function automatic logic [2:0] header_verdict();
    logic [63:0] phoff;
    logic [64:0] tab_end;
    if (m_hdr[0] != 8'h7f || m_hdr[1] != 8'h45 || m_hdr[2] != 8'h4c ||
        m_hdr[3] != 8'h46 || m_hdr[4] != 8'd2 || m_hdr[5] != 8'd1 ||
        m_hdr[6] != 8'd1 || le(m_hdr, 16, 2) != 2 || le(m_hdr, 18, 2) != 183 ||
        le(m_hdr, 20, 4) != 1 || le(m_hdr, 52, 2) != HDR_BYTES ||
        le(m_hdr, 54, 2) != ENT_BYTES)
      return ST_HEADER;
    if (le(m_hdr, 24, 8) != m_entry) return ST_ENTRY;
    phoff = le(m_hdr, 32, 8);
    tab_end = {1'b0, phoff} + 65'(le(m_hdr, 56, 2) * ENT_BYTES);
    if (tab_end[64]) return ST_OVERFLOW;
    if (tab_end[63:0] > m_len || phoff < HDR_BYTES) return ST_HEADER;
    return ST_OK;
  endfunction

  function automatic logic [2:0] segment_verdict();
    logic [63:0] offset, paddr, filesz, memsz, mask;
    logic [64:0] img_end, seg_end, rounded;
    if (le(m_ent, 0, 4) != 1) return ST_OK;
    offset = le(m_ent, 8, 8);
    paddr  = le(m_ent, 24, 8);
    filesz = le(m_ent, 32, 8);
    memsz  = le(m_ent, 40, 8);
    if (filesz > memsz) return ST_RANGE;
    img_end = {1'b0, offset} + {1'b0, filesz};
    if (img_end[64]) return ST_OVERFLOW;
    if (img_end[63:0] > m_len) return ST_RANGE;
    mask = (64'd1 << m_shift) - 64'd1;
    seg_end = {1'b0, paddr} + {1'b0, memsz};
    if (seg_end[64]) return ST_OVERFLOW;
    rounded = {1'b0, seg_end[63:0]} + {1'b0, mask};
    if (rounded[64]) return ST_OVERFLOW;
    if ((rounded[63:0] & ~mask) > m_limit) return ST_RANGE;
    return ST_OK;
  endfunction

  // advance the model by one accepted byte
  task automatic verdict_step(input logic [7:0] b, input logic last);
    logic        emit;
    logic [2:0]  st;
    logic [63:0] phoff, k;
    verdict_t    v;
    emit = 1'b0;
    st = ST_OK;
    if (!m_done) begin
      if (m_pos == 0 && m_len < HDR_BYTES) begin
        emit = 1'b1;
        st = ST_HEADER;
      end else if (m_pos < HDR_BYTES) begin
        m_hdr[m_pos] = b;
        if (m_pos == HDR_BYTES - 1) begin
          st = header_verdict();
          if (st != ST_OK || le(m_hdr, 56, 2) == 0) emit = 1'b1;
        end
      end else begin
        phoff = le(m_hdr, 32, 8);
        if (m_pos >= phoff) begin
          k = (m_pos - phoff) - {48'd0, m_seen} * 64'd56;
          if (k < ENT_BYTES) begin
            m_ent[k] = b;
            if (k == ENT_BYTES - 1) begin
              st = segment_verdict();
              m_seen = m_seen + 16'd1;
              if (st != ST_OK || 64'(m_seen) >= le(m_hdr, 56, 2)) emit = 1'b1;
            end
          end
        end
      end
      if (!emit && last) begin
        emit = 1'b1;
        st = ST_HEADER;
      end
      if (emit) begin
        m_done = 1'b1;
        if (forced_st >= 0) st = 3'(forced_st);
        v.st = st;
        v.entry = (st == ST_OK) ? le(m_hdr, 24, 8) : 64'd0;
        verdict_q.push_back(v);
      end
    end
    if (last) begin
      m_pos = '0;
      m_seen = '0;
      m_done = 1'b0;
    end else if (m_pos != MAX64) begin
      m_pos = m_pos + 64'd1;
    end
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_LEN:   m_len = val;
      CFG_ENTRY: m_entry = val;
      CFG_LIMIT: m_limit = val;
      CFG_PAGE:  m_shift = val[4:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int n;
    n = quiet ? 0 : $urandom_range(0, 7);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tdata <= b;
    in_tlast <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    verdict_step(b, last);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic send_image();
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
  endtask

  function automatic void put(input int at, input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) img[at + i] = v[8*i +: 8];
  endfunction

  // image from the current register values; entries follow the header and gap
  function automatic void build_image(input flaw_t flaw, input int nph, input int gap,
                                      input int tail);
    int          size, base, idx;
    logic [63:0] phoff, filesz, memsz;
    int          hdr_spots [11] = '{0, 1, 2, 3, 4, 5, 6, 16, 18, 20, 52};
    size = 64 + gap + 56 * nph + tail;
    img = new[size];
    foreach (img[i]) img[i] = 8'($urandom);
    img[0] = 8'h7f; img[1] = 8'h45; img[2] = 8'h4c; img[3] = 8'h46;
    img[4] = 8'd2; img[5] = 8'd1; img[6] = 8'd1;
    put(16, 2, 2); put(18, 183, 2); put(20, 1, 4);
    put(24, flaw == F_ENTRY ? ~m_entry : m_entry, 8);
    phoff = 64 + gap;
    if (flaw == F_PHLOW) phoff = $urandom_range(0, 63);
    // close enough to the top that one 56-byte entry carries the sum over
    if (flaw == F_PHOVF) phoff = MAX64 - $urandom_range(0, 55);
    put(32, phoff, 8);
    put(52, 64, 2); put(54, 56, 2); put(56, nph, 2);
    if (flaw == F_MAGIC) begin
      idx = hdr_spots[$urandom_range(0, 10)];
      img[idx] = img[idx] ^ (8'd1 << $urandom_range(0, 7));
    end
    for (int e = 0; e < nph; e++) begin
      base = 64 + gap + 56 * e;
      filesz = $urandom_range(0, 32);
      memsz = filesz + $urandom_range(0, 4096);
      put(base, flaw == F_NOLOAD ? 64'($urandom_range(2, 7)) : 64'd1, 4);
      put(base + 8, $urandom_range(0, 16), 8);
      put(base + 24, $urandom_range(0, 1 << 20), 8);
      put(base + 32, filesz, 8);
      put(base + 40, memsz, 8);
      if (e == 0) begin
        case (flaw)
          F_FILESZ:   begin put(base + 32, 64'd9, 8); put(base + 40, 64'd8, 8); end
          F_FILEEND:  begin put(base + 8, m_len, 8); put(base + 32, 1, 8);
                            put(base + 40, 1, 8); end
          F_FILEOVF:  begin put(base + 8, MAX64, 8); put(base + 32, 1, 8);
                            put(base + 40, 1, 8); end
          F_LIMIT:    put(base + 24, m_limit + 64'd1, 8);
          F_SEGOVF:   put(base + 24, MAX64, 8);
          F_ROUNDOVF: put(base + 24, MAX64 - memsz, 8);
          default: ;
        endcase
      end
    end
    if (flaw == F_TRUNC) img = new[$urandom_range(1, size - 1)](img);
  endfunction

  task automatic run_case(input case_t c);
    int tail;
    tail = $urandom_range(0, 3);
    settle();
    write_reg(CFG_LEN, c.len != 0 ? c.len : 64'(64 + c.gap + 56 * c.nph + tail));
    write_reg(CFG_ENTRY, c.entry);
    write_reg(CFG_LIMIT, c.limit);
    write_reg(CFG_PAGE, 64'(c.shift));
    build_image(c.flaw, c.nph, c.gap, tail);
    forced_st = c.typed_st;
    send_image();
    forced_st = -1;
  endtask

  localparam logic [63:0] EP = 64'h0000_0000_4008_0000;
  localparam logic [63:0] LIM = 64'h0000_0001_0000_0000;

  case_t directed [18] = '{
    '{64'd10, EP, LIM, 5'd12, F_NONE, 1, 0, int'(ST_HEADER)},   // short image
    '{64'd0, EP, LIM, 5'd12, F_NONE, 0, 0, -1},                 // no program headers
    '{64'd0, EP, LIM, 5'd12, F_MAGIC, 1, 0, int'(ST_HEADER)},
    '{64'd0, EP, LIM, 5'd12, F_ENTRY, 1, 0, int'(ST_ENTRY)},
    '{64'd0, EP, LIM, 5'd12, F_PHLOW, 1, 0, int'(ST_HEADER)},   // table below header
    '{64'd0, EP, LIM, 5'd12, F_PHOVF, 1, 0, int'(ST_OVERFLOW)},
    '{64'd0, EP, LIM, 5'd13, F_FILESZ, 1, 0, int'(ST_RANGE)},
    '{64'd0, EP, LIM, 5'd14, F_FILEEND, 1, 0, int'(ST_RANGE)},
    '{MAX64, EP, LIM, 5'd12, F_FILEOVF, 1, 0, int'(ST_OVERFLOW)},
    '{64'd0, EP, LIM, 5'd15, F_LIMIT, 1, 0, int'(ST_RANGE)},
    '{64'd0, EP, LIM, 5'd16, F_SEGOVF, 1, 0, int'(ST_OVERFLOW)},
    '{64'd0, EP, LIM, 5'd12, F_ROUNDOVF, 1, 0, int'(ST_OVERFLOW)},
    '{64'd0, EP, LIM, 5'd12, F_TRUNC, 2, 0, int'(ST_HEADER)},   // early end
    '{64'd0, EP, LIM, 5'd12, F_NOLOAD, 2, 0, -1},
    '{64'd0, EP, LIM, 5'd12, F_NONE, 2, 9, -1},                 // gap before table
    '{64'd0, 64'd0, 64'd0, 5'd0, F_NONE, 1, 0, -1},             // odd page shifts
    '{64'd0, MAX64, MAX64, 5'd31, F_NONE, 1, 0, -1},
    '{MAX64, MAX64, MAX64, 5'd16, F_NONE, 3, 2, -1}
  };

  // result side: random stalls, with one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_stall) begin
        long_stall = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      n = quiet ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %h", out_tdata);
      end else begin
        v = verdict_q.pop_front();
        if (out_tdata[2:0] != v.st || out_tdata[66:3] != v.entry) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected status %0d entry %h, got status %0d entry %h",
                     v.st, v.entry, out_tdata[2:0], out_tdata[66:3]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int     img_count;
    m_len = '0; m_entry = '0; m_limit = '0; m_shift = 5'd12;
    m_pos = '0; m_seen = '0; m_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) run_case(directed[i]);

    // fill the block while the result side holds off
    settle();
    write_reg(CFG_LEN, 64'd0);
    long_stall = 1'b1;
    quiet = 1'b1;
    for (int i = 0; i < 30; i++) send_byte(8'($urandom), 1'b1);
    quiet = 1'b0;

    img_count = 0;
    while (n_bytes < 1600 || img_count < 4) begin
      if (img_count % 4 == 0) begin
        settle();
        case ($urandom_range(0, 7))
          0:       write_reg(CFG_LEN, 64'($urandom_range(0, 63)));
          1, 2:    write_reg(CFG_LEN, MAX64);
          default: write_reg(CFG_LEN, 64'($urandom_range(64, 4096)));
        endcase
        write_reg(CFG_ENTRY, {$urandom, $urandom});
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_LIMIT, MAX64);
          1:       write_reg(CFG_LIMIT, 64'd0);
          default: write_reg(CFG_LIMIT, {32'd0, $urandom});
        endcase
        write_reg(CFG_PAGE, $urandom_range(0, 5) == 0 ? 64'($urandom_range(0, 31))
                                                      : 64'($urandom_range(12, 16)));
      end
      if ($urandom_range(0, 3) == 0) quiet = ~quiet;
      if ($urandom_range(0, 4) == 0) begin
        img = new[$urandom_range(1, 12)];
        foreach (img[i]) img[i] = 8'($urandom);
      end else begin
        build_image($urandom_range(0, 1) ? F_NONE : flaw_t'($urandom_range(1, 12)),
                    $urandom_range(0, 3), $urandom_range(0, 8), $urandom_range(0, 4));
      end
      send_image();
      img_count++;
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;

    wait (verdict_q.size() == 0);
    repeat (20) @(negedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/eic_pkg.sv
src/eic_front.sv
src/eic_queue.sv
src/eic_back.sv
src/elf64_image_checker.sv
sim/elf64_image_checker_tb.sv
